@@ rtl/cbf_pkg.sv @@
`timescale 1ns / 1ps

package cbf_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_FIRST_CHAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_SECOND_CHAR = 2'd2;

    // Register reset values
    localparam logic [LENGTH_W-1:0] PAYLOAD_LENGTH_RST = 16'd1;
    localparam logic [BYTE_W-1:0]   NAME_CHAR_RST      = 8'd65;

    // Framing bytes
    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h16;
    localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h1B;
    localparam logic [BYTE_W-1:0] EOT_BYTE  = 8'h17;

    // Slot index within the byte sequence one item can cause
    localparam int SLOT_W = 4;
    localparam logic [SLOT_W-1:0] SLOT_SYNC_FIRST = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_SYNC_LAST  = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_ESC        = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_LEN_HI     = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_LEN_LO     = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_NAME_1     = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_NAME_2     = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_DATA       = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_EOT        = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_SUM_FIRST  = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_SUM_LAST   = 4'd13;

    // Queue depth between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // One classified item, as handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0]   data;
        logic                header;
        logic                last;
        logic [LENGTH_W-1:0] limit;
        logic [BYTE_W-1:0]   name_1;
        logic [BYTE_W-1:0]   name_2;
        logic [BYTE_W-1:0]   sum;
    } cmd_t;

    // Back-end sequencer phase
    typedef enum logic {
        PH_FRESH,
        PH_MID
    } phase_t;

endpackage

@@ rtl/cassette_block_framer.sv @@
`timescale 1ns / 1ps
// Each accepted byte is written to the command queue and then registered in the output register.
// Inside a block one payload byte is taken per cycle while the queue is not full and m_ready
// holds; the first byte of a block also emits the header before its data, the last the trailer.
// The output register sets the rate: one result byte leaves per cycle while m_ready is high.
// Reset (aresetn low, synchronous) clears position, checksum, queue and output valid.
module cassette_block_framer #(
    parameter int CmdFifoDepth = cbf_pkg::CMD_FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cbf_pkg::BYTE_W-1:0]     s_payload_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cbf_pkg::BYTE_W-1:0]     m_out_byte,
    output logic                           m_run_last,
    output logic                           m_block_end
);
    import cbf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_push_cmd;
    cmd_t q_head_cmd;

    // Accept and classify payload bytes
    cbf_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (q_push_cmd)
    );

    // Decouple front and back
    cbf_fifo #(
        .Depth (CmdFifoDepth)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Emit header, payload and trailer bytes
    cbf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_head_valid),
        .head_cmd    (q_head_cmd),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_run_last  (m_run_last),
        .m_block_end (m_block_end)
    );

endmodule

@@ rtl/cbf_front.sv @@
`timescale 1ns / 1ps

module cbf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [cbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cbf_pkg::BYTE_W-1:0]    s_payload_byte,
    input  logic                          q_full,
    output logic                          q_push,
    output cbf_pkg::cmd_t                 q_cmd
);
    import cbf_pkg::*;

    logic [LENGTH_W-1:0] payload_length_reg;
    logic [BYTE_W-1:0]   name_first_reg;
    logic [BYTE_W-1:0]   name_second_reg;
    logic [LENGTH_W-1:0] position_reg, position_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;

    logic [LENGTH_W-1:0] limit;
    logic [BYTE_W-1:0]   sum_new;
    logic                last_byte;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            payload_length_reg <= PAYLOAD_LENGTH_RST;
            name_first_reg     <= NAME_CHAR_RST;
            name_second_reg    <= NAME_CHAR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PAYLOAD_LENGTH:   payload_length_reg <= cfg_wdata;
                CFG_NAME_FIRST_CHAR:  name_first_reg     <= cfg_wdata[BYTE_W-1:0];
                CFG_NAME_SECOND_CHAR: name_second_reg    <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the incoming byte
    assign limit     = payload_length_reg - LENGTH_W'(1);
    assign last_byte = (position_reg >= limit);
    assign sum_new   = sum_reg + s_payload_byte;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.data   = s_payload_byte;
        q_cmd.header = (position_reg == '0);
        q_cmd.last   = last_byte;
        q_cmd.limit  = limit;
        q_cmd.name_1 = name_first_reg;
        q_cmd.name_2 = name_second_reg;
        q_cmd.sum    = sum_new;
    end

    // Advance position and checksum on each transfer
    always_comb begin
        position_next = position_reg;
        sum_next      = sum_reg;
        if (q_push) begin
            if (last_byte) begin
                position_next = '0;
                sum_next      = '0;
            end else begin
                position_next = position_reg + LENGTH_W'(1);
                sum_next      = sum_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            sum_reg      <= '0;
        end else begin
            position_reg <= position_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

@@ rtl/cbf_fifo.sv @@
`timescale 1ns / 1ps

module cbf_fifo #(
    parameter int Depth = cbf_pkg::CMD_FIFO_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cbf_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output cbf_pkg::cmd_t head_cmd
);
    import cbf_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

    cmd_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrMax) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrMax) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CntW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/cbf_back.sv @@
`timescale 1ns / 1ps

module cbf_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  cbf_pkg::cmd_t              head_cmd,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cbf_pkg::BYTE_W-1:0] m_out_byte,
    output logic                       m_run_last,
    output logic                       m_block_end
);
    import cbf_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              block_end_reg;

    logic [SLOT_W-1:0] first_slot;
    logic [SLOT_W-1:0] end_slot;
    logic [SLOT_W-1:0] cur_slot;
    logic [BYTE_W-1:0] cur_byte;
    logic              load;
    logic              emit;
    logic              cur_end;

    // Slot range of the head entry
    assign first_slot = head_cmd.header ? SLOT_SYNC_FIRST : SLOT_DATA;
    assign end_slot   = head_cmd.last ? SLOT_SUM_LAST : SLOT_DATA;
    assign cur_slot   = (phase_reg == PH_FRESH) ? first_slot : slot_reg;
    assign cur_end    = (cur_slot == end_slot);

    assign load = !m_valid_reg || m_ready;
    assign emit = head_valid && load;
    assign pop  = emit && cur_end;

    // Next state
    always_comb begin
        phase_next = phase_reg;
        slot_next  = slot_reg;
        if (emit) begin
            if (cur_end) begin
                phase_next = PH_FRESH;
            end else begin
                phase_next = PH_MID;
                slot_next  = cur_slot + SLOT_W'(1);
            end
        end
    end

    // Select the byte for the current slot
    always_comb begin
        case (cur_slot) inside
            [SLOT_SYNC_FIRST:SLOT_SYNC_LAST]: cur_byte = SYNC_BYTE;
            SLOT_ESC:                         cur_byte = ESC_BYTE;
            SLOT_LEN_HI:                      cur_byte = head_cmd.limit[LENGTH_W-1:BYTE_W];
            SLOT_LEN_LO:                      cur_byte = head_cmd.limit[BYTE_W-1:0];
            SLOT_NAME_1:                      cur_byte = head_cmd.name_1;
            SLOT_NAME_2:                      cur_byte = head_cmd.name_2;
            SLOT_DATA:                        cur_byte = head_cmd.data;
            SLOT_EOT:                         cur_byte = EOT_BYTE;
            [SLOT_SUM_FIRST:SLOT_SUM_LAST]:   cur_byte = head_cmd.sum;
            default:                          cur_byte = '0;
        endcase
    end

    // Output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FRESH;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until the transfer
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_byte_reg  <= cur_byte;
            run_last_reg  <= cur_end;
            block_end_reg <= (cur_slot == SLOT_SUM_LAST);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = out_byte_reg;
    assign m_run_last  = run_last_reg;
    assign m_block_end = block_end_reg;

endmodule
